/* src/msc_pkg.sv */
package msc_pkg;

  localparam int unsigned VALUE_W       = 16;
  localparam int unsigned COUNT_W       = 3;
  localparam int unsigned MAX_VALUE_DEF = 65535;
  // largest root that can matter for a value of VALUE_W bits
  localparam int unsigned ROOT_CAP      = (1 << (VALUE_W / 2)) - 1;

  typedef logic [COUNT_W-1:0] count_t;

  localparam count_t CNT_ZERO  = count_t'(0);
  localparam count_t CNT_ONE   = count_t'(1);
  localparam count_t CNT_TWO   = count_t'(2);
  localparam count_t CNT_THREE = count_t'(3);
  localparam count_t CNT_FOUR  = count_t'(4);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_PAIR,
    ST_TCHK,
    ST_TRIPLE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic   load;          // capture word, set up the single-square scan
    logic   start_pair;    // b = 1, c = top, rest = n
    logic   start_a;       // a = 1
    logic   start_triple;  // rest = n - a*a, b = 1, c = top
    logic   next_a;        // a = a + 1
    logic   step;          // move one pointer of the pair scan
    logic   out_load;
    count_t out_code;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic hit;
    logic over;
    logic b_last;
    logic c_last;
    logic a_last;
    logic a_ok;
    logic out_free;
  } status_t;

  // floor(sqrt(x)), elaboration use only
  function automatic int unsigned root_floor(input int unsigned x);
    int unsigned rem;
    int unsigned res;
    int unsigned bitv;
    rem  = x;
    res  = 0;
    bitv = 32'h4000_0000;
    for (int i = 0; i < 16; i++) begin
      if (bitv != 0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

endpackage

/* src/msc_if.sv */
interface msc_in_if;
  logic                        valid;
  logic                        ready;
  logic [msc_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface msc_out_if;
  logic            valid;
  logic            ready;
  msc_pkg::count_t square_count;

  modport source (output valid, output square_count, input ready);
  modport sink   (input valid, input square_count, output ready);
endinterface

/* src/min_squares_count_core.sv */
// A zero word leaves the search from state SQ straight for DONE; every other word scans
// the root range B = min(floor(sqrt(MAX_VALUE)), 255).
// Throughput: one word at a time; the pair scan in the datapath moves one root pointer
// per cycle with one add and compare.
// A new word is taken while the previous result waits in the output register.
// Reset (rst_n low, synchronous) returns the controller to idle and empties the output.
module min_squares_count_core #(
  parameter int unsigned MAX_VALUE = msc_pkg::MAX_VALUE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  msc_in_if.sink    in_word,
  msc_out_if.source out_word
);

  msc_pkg::cmd_t    cmd;
  msc_pkg::status_t status;

  msc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_word.valid),
    .in_ready (in_word.ready),
    .status   (status),
    .cmd      (cmd)
  );

  msc_dp #(
    .MAX_VALUE (MAX_VALUE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_value  (in_word.value),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_word.valid),
    .out_ready (out_word.ready),
    .out_count (out_word.square_count)
  );

endmodule

/* src/msc_ctrl.sv */
module msc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  msc_pkg::status_t  status,
  output msc_pkg::cmd_t     cmd
);

  msc_pkg::state_t state_r, state_nxt;
  msc_pkg::count_t res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign in_ready = (state_r == msc_pkg::ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    res_nxt      = res_r;
    cmd          = '0;
    cmd.out_code = res_r;
    case (state_r)
      msc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = msc_pkg::ST_SQ;
        end
      end
      msc_pkg::ST_SQ: begin
        if (status.zero) begin
          res_nxt   = msc_pkg::CNT_ZERO;
          state_nxt = msc_pkg::ST_DONE;
        end else if (status.hit) begin
          res_nxt   = msc_pkg::CNT_ONE;
          state_nxt = msc_pkg::ST_DONE;
        end else if (status.over && !status.c_last) begin
          cmd.step = 1'b1;
        end else begin
          cmd.start_pair = 1'b1;
          state_nxt      = msc_pkg::ST_PAIR;
        end
      end
      msc_pkg::ST_PAIR: begin
        if (status.hit) begin
          res_nxt   = msc_pkg::CNT_TWO;
          state_nxt = msc_pkg::ST_DONE;
        end else if (status.over ? !status.c_last : !status.b_last) begin
          cmd.step = 1'b1;
        end else begin
          cmd.start_a = 1'b1;
          state_nxt   = msc_pkg::ST_TCHK;
        end
      end
      msc_pkg::ST_TCHK: begin
        if (status.a_ok) begin
          cmd.start_triple = 1'b1;
          state_nxt        = msc_pkg::ST_TRIPLE;
        end else begin
          res_nxt   = msc_pkg::CNT_FOUR;
          state_nxt = msc_pkg::ST_DONE;
        end
      end
      msc_pkg::ST_TRIPLE: begin
        if (status.hit) begin
          res_nxt   = msc_pkg::CNT_THREE;
          state_nxt = msc_pkg::ST_DONE;
        end else if (status.over ? !status.c_last : !status.b_last) begin
          cmd.step = 1'b1;
        end else if (status.a_last) begin
          res_nxt   = msc_pkg::CNT_FOUR;
          state_nxt = msc_pkg::ST_DONE;
        end else begin
          cmd.next_a = 1'b1;
          state_nxt  = msc_pkg::ST_TCHK;
        end
      end
      msc_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = msc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = msc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/msc_dp.sv */
module msc_dp #(
  parameter int unsigned MAX_VALUE = msc_pkg::MAX_VALUE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [msc_pkg::VALUE_W-1:0] in_value,
  input  msc_pkg::cmd_t               cmd,
  output msc_pkg::status_t            status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output msc_pkg::count_t             out_count
);

  localparam int unsigned VW    = msc_pkg::VALUE_W;
  localparam int unsigned BOUND = msc_pkg::root_floor(MAX_VALUE);
  localparam int unsigned BM    = (BOUND < msc_pkg::ROOT_CAP) ? BOUND : msc_pkg::ROOT_CAP;
  localparam int unsigned RW    = (BM < 2) ? 1 : $clog2(BM + 1);

  localparam logic [RW-1:0] ROOT_TOP = RW'(BM);
  localparam logic [RW-1:0] ROOT_ONE = RW'(1);
  localparam logic [VW-1:0] SQ_TOP   = VW'(BM * BM);

  logic [VW-1:0] n_r, n_nxt;
  logic [VW-1:0] rest_r, rest_nxt;
  logic [RW-1:0] a_r, a_nxt;
  logic [VW-1:0] asq_r, asq_nxt;
  logic [RW-1:0] b_r, b_nxt;
  logic [VW-1:0] bsq_r, bsq_nxt;
  logic [RW-1:0] c_r, c_nxt;
  logic [VW-1:0] csq_r, csq_nxt;
  logic          out_valid_r, out_valid_nxt;
  msc_pkg::count_t out_count_r, out_count_nxt;

  logic [VW:0]   sum;
  logic [RW:0]   a_odd, b_odd, c_odd;

  // (x+1)^2 - x^2 = 2x+1, c^2 - (c-1)^2 = 2c-1
  assign a_odd = {a_r, 1'b1};
  assign b_odd = {b_r, 1'b1};
  assign c_odd = {c_r - ROOT_ONE, 1'b1};
  assign sum   = {1'b0, bsq_r} + {1'b0, csq_r};

  assign status.zero     = (n_r == '0);
  assign status.hit      = (sum == {1'b0, rest_r});
  assign status.over     = (sum > {1'b0, rest_r});
  assign status.b_last   = (b_r == ROOT_TOP);
  assign status.c_last   = (c_r == ROOT_ONE);
  assign status.a_last   = (a_r == ROOT_TOP);
  assign status.a_ok     = (asq_r < n_r);
  assign status.out_free = !out_valid_r || out_ready;

  always_comb begin
    n_nxt    = n_r;
    rest_nxt = rest_r;
    a_nxt    = a_r;
    asq_nxt  = asq_r;
    b_nxt    = b_r;
    bsq_nxt  = bsq_r;
    c_nxt    = c_r;
    csq_nxt  = csq_r;
    if (cmd.load) begin
      n_nxt    = in_value;
      rest_nxt = in_value;
      b_nxt    = '0;
      bsq_nxt  = '0;
      c_nxt    = ROOT_TOP;
      csq_nxt  = SQ_TOP;
    end else if (cmd.start_pair || cmd.start_triple) begin
      rest_nxt = cmd.start_triple ? (n_r - asq_r) : n_r;
      b_nxt    = ROOT_ONE;
      bsq_nxt  = VW'(1);
      c_nxt    = ROOT_TOP;
      csq_nxt  = SQ_TOP;
    end else if (cmd.step) begin
      if (status.over) begin
        c_nxt   = c_r - ROOT_ONE;
        csq_nxt = csq_r - VW'(c_odd);
      end else begin
        b_nxt   = b_r + ROOT_ONE;
        bsq_nxt = bsq_r + VW'(b_odd);
      end
    end
    if (cmd.start_a) begin
      a_nxt   = ROOT_ONE;
      asq_nxt = VW'(1);
    end else if (cmd.next_a) begin
      a_nxt   = a_r + ROOT_ONE;
      asq_nxt = asq_r + VW'(a_odd);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = cmd.out_code;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    rest_r      <= rest_nxt;
    a_r         <= a_nxt;
    asq_r       <= asq_nxt;
    b_r         <= b_nxt;
    bsq_r       <= bsq_nxt;
    c_r         <= c_nxt;
    csq_r       <= csq_nxt;
    out_count_r <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_count = out_count_r;

endmodule

/* src/msc_chk.sv */
module msc_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [msc_pkg::VALUE_W-1:0] in_value,
  input logic                        out_valid,
  input logic                        out_ready,
  input msc_pkg::count_t             out_count
);

  // result never above four
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= msc_pkg::CNT_FOUR))
    else $error("square count out of range");

  // one word in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready high right after accept");

  // output register empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a zero word taken while the output is empty takes the fast exit and gives zero squares
  a_zero_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_value == '0) && !out_valid) |=> ##2 (out_valid
      && (out_count == msc_pkg::CNT_ZERO)))
    else $error("zero word gave wrong or late result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_count)))
    else $error("stalled result changed");

endmodule

bind min_squares_count_core msc_chk u_msc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_word.valid),
  .in_ready  (in_word.ready),
  .in_value  (in_word.value),
  .out_valid (out_word.valid),
  .out_ready (out_word.ready),
  .out_count (out_word.square_count)
);

/* sim/tb_min_squares_count_core.sv */
`timescale 1ns / 100ps

module tb_min_squares_count_core;

  localparam int unsigned TB_MAX_VALUE  = msc_pkg::MAX_VALUE_DEF;
  localparam int unsigned HOLD_CYCLES   = 16000;
  localparam int unsigned SETTLE_CYCLES = 40;
  // longest quiet stretch: one full four-term search plus hold-off and stalls, taken 4x
  localparam int unsigned WATCHDOG_LIMIT = 4 * (2 * 255 * 255 + 3 * 255 + 4 + HOLD_CYCLES + 2 * 9);

  logic clk = 1'b0;
  logic rst_n;

  msc_in_if  in_if ();
  msc_out_if out_if ();

  min_squares_count_core #(
    .MAX_VALUE(TB_MAX_VALUE)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_if),
    .out_word(out_if)
  );

  always #5 clk = ~clk;

  msc_pkg::count_t             exp_counts[$];
  logic [msc_pkg::VALUE_W-1:0] sent_values[$];
  int                          fail_count   = 0;
  bit                          idle_on      = 1'b1;
  int                          hold_req     = 0;
  int                          hold_done    = 0;
  int unsigned                 quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned root_of(input int unsigned x);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int b = 10; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic bit square_in_range(input int unsigned x, input int unsigned bound);
    int unsigned r;
    if (x == 0) return 1'b0;
    r = root_of(x);
    return (r * r == x) && (r <= bound);
  endfunction

  function automatic msc_pkg::count_t least_square_terms(
    input logic [msc_pkg::VALUE_W-1:0] value
  );
    int unsigned n;
    int unsigned bound;
    int unsigned rest;
    n     = value;
    bound = root_of(TB_MAX_VALUE);
    if (n == 0) return msc_pkg::CNT_ZERO;
    if (square_in_range(n, bound)) return msc_pkg::CNT_ONE;
    for (int unsigned a = 1; a <= bound && a * a < n; a++)
      if (square_in_range(n - a * a, bound)) return msc_pkg::CNT_TWO;
    for (int unsigned a = 1; a <= bound && a * a < n; a++) begin
      rest = n - a * a;
      for (int unsigned b = 1; b <= bound && b * b < rest; b++)
        if (square_in_range(rest - b * b, bound)) return msc_pkg::CNT_THREE;
    end
    return msc_pkg::CNT_FOUR;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [msc_pkg::VALUE_W-1:0] v);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk); while (!in_if.ready);
    exp_counts.push_back(least_square_terms(v));
    sent_values.push_back(v);
    in_if.valid <= 1'b0;
    // one bubble so valid never drops and rises in the same step
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (exp_counts.size() != 0) @(posedge clk);
  endtask

  function automatic logic [msc_pkg::VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    // mostly small words, the search time grows with the root range
    if (sel < 80) return msc_pkg::VALUE_W'($urandom_range(0, 1023));
    else if (sel < 95) return msc_pkg::VALUE_W'($urandom_range(1024, 8191));
    else return msc_pkg::VALUE_W'($urandom_range(0, 65535));
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done != hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_done++;
      end else if (idle_on && rst_n && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 9);
        out_if.ready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic report_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin : result_check
    msc_pkg::count_t             want;
    logic [msc_pkg::VALUE_W-1:0] src;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (exp_counts.size() == 0) begin
        report_fail($sformatf("unexpected result word: square_count=%0d", out_if.square_count));
      end else begin
        want = exp_counts.pop_front();
        src  = sent_values.pop_front();
        if (out_if.square_count !== want)
          report_fail($sformatf("value %0d: square_count expected %0d, got %0d",
                                src, want, out_if.square_count));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[min_squares_count_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    logic [msc_pkg::VALUE_W-1:0] vals[$];
    vals = {16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd7, 16'd12, 16'd15, 16'd25, 16'd28,
            16'd50, 16'd112, 16'd32768, 16'd65025, 16'd65534, 16'd65533, 16'hAAAA,
            16'h5555, 16'd65280, 16'd65535, 16'd0};
    foreach (vals[i]) send_word(vals[i]);
  endtask

  task automatic test_random();
    repeat (60) send_word(pick_value());
  endtask

  // sink holds off while words keep coming, so the core fills and stalls its input
  task automatic test_backpressure();
    wait_drained();
    hold_req++;
    repeat (8) send_word(msc_pkg::VALUE_W'($urandom_range(0, 255)));
    while (hold_done != hold_req) @(posedge clk);
  endtask

  task automatic test_drain_pause();
    repeat (4) send_word(pick_value());
    wait_drained();
    repeat (4) send_word(pick_value());
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    repeat (15) send_word(pick_value());
  endtask

  initial begin : run
    in_if.valid = 1'b0;
    in_if.value = '0;
    rst_n       = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    test_drain_pause();
    test_no_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && exp_counts.size() == 0) begin
      $display("[min_squares_count_core] OK");
    end else begin
      $display("[min_squares_count_core] ERROR");
    end
    $finish;
  end

endmodule
